### rtl/ebml_pkg.sv
// ----------------------------------------------------------------------------
// ebml_pkg
// Types and constants shared by the element header parser.
// ----------------------------------------------------------------------------
package ebml_pkg;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_ID_LEAD   = 2'd1;
  localparam logic [1:0] ERR_SIZE_LEAD = 2'd2;

  typedef enum logic [1:0] {
    PH_ID_LEAD,
    PH_ID_MORE,
    PH_SIZE_LEAD,
    PH_SIZE_MORE
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
  } byte_item_t;

  typedef struct packed {
    logic [1:0]  error_code;
    logic [63:0] element_id;
    logic [55:0] element_size;
    logic        unknown_size;
    logic [4:0]  header_length;
    logic [63:0] header_offset;
    logic [63:0] payload_offset;
  } header_item_t;

  // vint length from the lead byte; zero when the byte is invalid
  function automatic logic [3:0] lead_length(input logic [7:0] b, input logic [3:0] max_len);
    logic [3:0] len;
    len = 4'd0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        len = 4'(8 - i);
      end
    end
    if (len > max_len) begin
      len = 4'd0;
    end
    return len;
  endfunction

  // low 7*len bits set
  function automatic logic [55:0] ones_mask(input logic [3:0] len);
    logic [6:0]  nbits;
    logic [55:0] m;
    nbits = {3'b000, len} * 7'd7;
    for (int i = 0; i < 56; i++) begin
      m[i] = (7'(i) < nbits);
    end
    return m;
  endfunction

endpackage

### rtl/ebml_stream_if.sv
// ----------------------------------------------------------------------------
// ebml_stream_if
// Valid/ready channel carrying one request payload per transfer.
// ----------------------------------------------------------------------------
interface ebml_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### rtl/ebml_hdr_core.sv
// ----------------------------------------------------------------------------
// ebml_hdr_core
// Parse state and per-byte header logic; yields at most one result a byte.
// ----------------------------------------------------------------------------
module ebml_hdr_core #(
  parameter int MAX_VINT_BYTES = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    accept,
  input  logic [7:0]              data_byte,
  output logic                    res_valid,
  output ebml_pkg::header_item_t  res
);
  import ebml_pkg::*;

  phase_t      phase, phase_next;
  logic [2:0]  bytes_left, bytes_left_next;
  logic [63:0] id_acc, id_acc_next;
  logic [3:0]  id_length, id_length_next;
  logic [55:0] size_acc, size_acc_next;
  logic [3:0]  size_length, size_length_next;
  logic [63:0] byte_position, byte_position_next;
  logic [63:0] start_position, start_position_next;

  logic [3:0]  len;
  logic [3:0]  len_m1;
  logic [2:0]  bl_dec;
  logic [7:0]  lead_mask;
  logic        emit;

  assign len       = lead_length(data_byte, 4'(MAX_VINT_BYTES));
  assign len_m1    = len - 4'd1;
  assign bl_dec    = bytes_left - 3'd1;
  assign lead_mask = (8'h80 >> len_m1) - 8'd1;

  always_comb begin
    phase_next          = phase;
    bytes_left_next     = bytes_left;
    id_acc_next         = id_acc;
    id_length_next      = id_length;
    size_acc_next       = size_acc;
    size_length_next    = size_length;
    start_position_next = (phase == PH_ID_LEAD) ? byte_position : start_position;
    byte_position_next  = byte_position + 64'd1;
    emit                = 1'b0;
    res_valid           = 1'b0;
    res                 = '0;
    res.header_offset   = start_position_next;

    case (phase)
      PH_ID_LEAD: begin
        if (len == 4'd0) begin
          res_valid       = 1'b1;
          res.error_code  = ERR_ID_LEAD;
          bytes_left_next = 3'd0;
        end else begin
          id_acc_next     = {56'd0, data_byte};
          id_length_next  = len;
          bytes_left_next = len_m1[2:0];
          phase_next      = (len_m1[2:0] != 3'd0) ? PH_ID_MORE : PH_SIZE_LEAD;
        end
      end
      PH_ID_MORE: begin
        id_acc_next     = {id_acc[55:0], data_byte};
        bytes_left_next = bl_dec;
        if (bl_dec == 3'd0) begin
          phase_next = PH_SIZE_LEAD;
        end
      end
      PH_SIZE_LEAD: begin
        if (len == 4'd0) begin
          res_valid       = 1'b1;
          res.error_code  = ERR_SIZE_LEAD;
          phase_next      = PH_ID_LEAD;
          bytes_left_next = 3'd0;
        end else begin
          size_acc_next    = {48'd0, data_byte & lead_mask};
          size_length_next = len;
          bytes_left_next  = len_m1[2:0];
          if (len_m1[2:0] == 3'd0) begin
            emit = 1'b1;
          end else begin
            phase_next = PH_SIZE_MORE;
          end
        end
      end
      PH_SIZE_MORE: begin
        size_acc_next   = {size_acc[47:0], data_byte};
        bytes_left_next = bl_dec;
        if (bl_dec == 3'd0) begin
          emit = 1'b1;
        end
      end
      default: begin
        phase_next      = PH_ID_LEAD;
        bytes_left_next = 3'd0;
      end
    endcase

    if (emit) begin
      res_valid          = 1'b1;
      res.error_code     = ERR_NONE;
      res.element_id     = id_acc_next;
      res.element_size   = size_acc_next;
      res.unknown_size   = (size_acc_next == ones_mask(size_length_next));
      res.header_length  = {1'b0, id_length_next} + {1'b0, size_length_next};
      res.payload_offset = byte_position_next;
      phase_next         = PH_ID_LEAD;
      bytes_left_next    = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_ID_LEAD;
      bytes_left     <= 3'd0;
      id_acc         <= '0;
      id_length      <= 4'd0;
      size_acc       <= '0;
      size_length    <= 4'd0;
      byte_position  <= '0;
      start_position <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      bytes_left     <= bytes_left_next;
      id_acc         <= id_acc_next;
      id_length      <= id_length_next;
      size_acc       <= size_acc_next;
      size_length    <= size_length_next;
      byte_position  <= byte_position_next;
      start_position <= start_position_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_more_has_bytes: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_ID_MORE || phase == PH_SIZE_MORE) |-> bytes_left != 3'd0)
    else $error("continuation phase with no bytes left");

  a_lead_no_bytes: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_ID_LEAD || phase == PH_SIZE_LEAD) |-> bytes_left == 3'd0)
    else $error("lead phase with bytes left");

  a_pos_counts: assert property (@(posedge clk) disable iff (rst)
    accept |=> byte_position == $past(byte_position) + 64'd1)
    else $error("byte position did not advance");
`endif

endmodule

### rtl/ebml_out_buf.sv
// ----------------------------------------------------------------------------
// ebml_out_buf
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module ebml_out_buf (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  ebml_pkg::header_item_t push_data,
  output logic                   space,
  ebml_stream_if.source          headers
);
  import ebml_pkg::*;

  logic         out_valid;
  header_item_t out_data;
  logic         skid_valid;
  header_item_t skid_data;
  logic         pop;

  assign pop             = out_valid & headers.ready;
  assign space           = ~skid_valid;
  assign headers.valid   = out_valid;
  assign headers.payload = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
        if (push) begin
          out_data <= push_data;
        end
      end
    end else if (push) begin
      if (!out_valid) begin
        out_valid <= 1'b1;
        out_data  <= push_data;
      end else begin
        skid_valid <= 1'b1;
        skid_data  <= push_data;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry without output entry");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !skid_valid)
    else $error("request pushed into full buffer");
`endif

endmodule

### rtl/ebml_element_header_parser.sv
// ----------------------------------------------------------------------------
// ebml_element_header_parser
// Parses EBML element headers (ID vint, size vint) from a byte stream.
//
// byte_stream: one stream byte per request (data_byte). headers: one request
// per completed header or per bad lead byte, with error_code, element_id
// (marker kept), element_size (marker stripped), unknown_size, header_length,
// header_offset and payload_offset.
// Throughput: one byte per cycle while the output skid entry is free.
// Output: a result is registered into the output buffer as the byte that
// completes the header (or the bad lead byte) is accepted.
// Reset: parser idle awaiting an ID lead byte, byte position zero, output
// buffer empty.
// Stall: results sit in a two-entry output buffer; byte_stream.ready drops
// only while both entries are full, so bytes that finish no header keep
// flowing while one result waits.
// MAX_VINT_BYTES: lead bytes implying a longer vint are reported as errors.
// ----------------------------------------------------------------------------
module ebml_element_header_parser #(
  parameter int MAX_VINT_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst,
  ebml_stream_if.sink   byte_stream,
  ebml_stream_if.source headers
);
  import ebml_pkg::*;

  logic         accept;
  logic         res_valid;
  header_item_t res;
  logic         space;

  assign byte_stream.ready = space;
  assign accept            = byte_stream.valid & space;

  ebml_hdr_core #(
    .MAX_VINT_BYTES (MAX_VINT_BYTES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (byte_stream.payload.data_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  ebml_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept & res_valid),
    .push_data (res),
    .space     (space),
    .headers   (headers)
  );

endmodule
